// ===== rtl/crcfr_pkg.sv =====
package crcfr_pkg;

   // parse phases
   localparam logic [2:0] PH_SYNC    = 3'd0;
   localparam logic [2:0] PH_START   = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_LENCRC  = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_DATACRC = 3'd5;

   // frame events
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_OK       = 3'd1;
   localparam logic [2:0] EV_BADSTART = 3'd2;
   localparam logic [2:0] EV_LENCRC   = 3'd3;
   localparam logic [2:0] EV_DATACRC  = 3'd4;

   // register indexes
   localparam logic CSR_SYNC_BYTE  = 1'b0;
   localparam logic CSR_START_BYTE = 1'b1;

   localparam logic [7:0] SYNC_BYTE_RESET  = 8'hFF;
   localparam logic [7:0] START_BYTE_RESET = 8'h02;
   localparam logic [7:0] CRC_POLY         = 8'h8C;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [2:0] event_res;
      logic [7:0] frame_length;
   } result_type;

   // reflected CRC-8, one byte, LSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ b[k];
         c  = {1'b0, c[7:1]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/crcfr_parser.sv =====
module crcfr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             sync_byte,
   input  logic [7:0]             start_byte,
   output crcfr_pkg::result_type  result
);
   import crcfr_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] exp_len_ff, exp_len_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] count_inc;

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      result     = '0;
      case (phase_ff)
         PH_START: begin
            if (rx_byte == start_byte) begin
               phase_in = PH_LEN;
            end else begin
               phase_in         = PH_SYNC;
               result.event_res = EV_BADSTART;
            end
         end
         PH_LEN: begin
            exp_len_in = rx_byte;
            phase_in   = PH_LENCRC;
         end
         PH_LENCRC: begin
            if (crc8_step(8'd0, exp_len_ff) == rx_byte) begin
               count_in = 8'd0;
               crc_in   = 8'd0;
               phase_in = (exp_len_ff == 8'd0) ? PH_DATACRC : PH_DATA;
            end else begin
               phase_in         = PH_SYNC;
               result.event_res = EV_LENCRC;
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ff;
            crc_in               = crc8_step(crc_ff, rx_byte);
            count_in             = count_inc;
            if (count_inc == exp_len_ff) begin
               phase_in = PH_DATACRC;
            end
         end
         PH_DATACRC: begin
            phase_in = PH_SYNC;
            if (crc_ff == rx_byte) begin
               result.event_res    = EV_OK;
               result.frame_length = exp_len_ff;
            end else begin
               result.event_res = EV_DATACRC;
            end
         end
         default: begin
            // unused codes fall back to sync hunting
            phase_in = (rx_byte == sync_byte) ? PH_START : PH_SYNC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC;
         exp_len_ff <= 8'd0;
         count_ff   <= 8'd0;
         crc_ff     <= 8'd0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
      end
   end

endmodule

// ===== rtl/crc8_frame_receiver_top.sv =====
// Framed byte receiver with CRC-8 checks.
// Input channel req_*: one received byte per item (req_rx_byte).
// Result channel rsp_*: exactly one result per input item, in order, giving
// the echoed payload byte with its index, a frame event and the frame length
// on a good frame.
// Configuration: csr_wr_en writes csr_wdata into the sync byte (index 0) or
// the start byte (index 1); write only while no item is in flight.
// Path: an accepted item waits in the input register, then passes the parser
// into the result register once that register is empty or being read.
// Throughput: one item per cycle while results are taken; the CRC update is a
// single unrolled byte step between the two registers.
// Reset: parser returns to sync hunting, running CRC and counters clear,
// sync byte 0xFF, start byte 0x02, both pipeline stages empty.
// Stall: while rsp_ready is low a held result stays put; the input register
// still takes one more item, then req_ready drops until the result moves.
module crc8_frame_receiver_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_payload_valid,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_frame_length,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import crcfr_pkg::*;

   logic [7:0] sync_val_ff;
   logic [7:0] start_val_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type step_result;
   logic       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_val_ff  <= SYNC_BYTE_RESET;
         start_val_ff <= START_BYTE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SYNC_BYTE) begin
            sync_val_ff <= csr_wdata;
         end else begin
            start_val_ff <= csr_wdata;
         end
      end
   end

   // move the held item into the result register when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   crcfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .rx_byte    (in_byte_ff),
      .sync_byte  (sync_val_ff),
      .start_byte (start_val_ff),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_index = out_ff.payload_index;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_frame_length  = out_ff.frame_length;

`ifndef SYNTHESIS
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a stalled item");

   a_payload_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_event_res == EV_NONE)
      else $error("payload byte carries a frame event");

   a_length_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_OK |-> rsp_frame_length == 8'd0)
      else $error("frame length reported without a good frame");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced item did not reach the result register");
`endif

endmodule
